FILE: rtl/binary_to_decimal_ascii_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary to decimal ASCII unit
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define BDAU_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

// Antecedent in one cycle implies consequent in the next.
`define BDAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define BDAU_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define BDAU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/bdau_pkg.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII unit package
// Constants, microcode word layout and the microcode program.
// ----------------------------------------------------------------------------
package bdau_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int IN_BITS        = 32;
    localparam int CHAR_BITS      = 6;
    localparam int TDATA_IN_BITS  = 32;
    localparam int TDATA_OUT_BITS = 8;
    localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

    localparam int STEP_BITS = 2;
    localparam logic [STEP_BITS-1:0] STEP_WAIT = 2'd0;
    localparam logic [STEP_BITS-1:0] STEP_CONV = 2'd1;
    localparam logic [STEP_BITS-1:0] STEP_SKIP = 2'd2;
    localparam logic [STEP_BITS-1:0] STEP_EMIT = 2'd3;

    typedef enum logic [1:0] {
        COND_IN_ACC    = 2'd0,
        COND_BITS_DONE = 2'd1,
        COND_LEAD_DONE = 2'd2,
        COND_OUT_LAST  = 2'd3
    } t_cond;

    typedef struct packed {
        t_cond                 cond;
        logic [STEP_BITS-1:0]  jump;
        logic                  s_ready;
        logic                  m_valid;
        logic                  conv_en;
        logic                  skip_en;
    } t_uword;

    function automatic t_uword ucode(input logic [STEP_BITS-1:0] pc);
        t_uword w;
        w = '0;
        case (pc)
            STEP_WAIT: begin
                w.cond    = COND_IN_ACC;
                w.jump    = STEP_CONV;
                w.s_ready = 1'b1;
            end
            STEP_CONV: begin
                w.cond    = COND_BITS_DONE;
                w.jump    = STEP_SKIP;
                w.conv_en = 1'b1;
            end
            STEP_SKIP: begin
                w.cond    = COND_LEAD_DONE;
                w.jump    = STEP_EMIT;
                w.skip_en = 1'b1;
            end
            STEP_EMIT: begin
                w.cond    = COND_OUT_LAST;
                w.jump    = STEP_WAIT;
                w.m_valid = 1'b1;
            end
            default: begin
                w.cond = COND_IN_ACC;
                w.jump = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/binary_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII unit
// Converts an unsigned binary number to decimal ASCII digits, most
// significant first, without leading zeros, under a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                       | tlast
//  s (in)   | in  | [31:0] value                | -
//  m (out)  | out | [5:0] digit_char, [7:6] 0   | last_digit
//
//  An item is loaded, then converted by VALUE_BITS shift-add-3 steps; leading
//  zero digits are then skipped until the leading digit is found, and each
//  digit is emitted in turn, held by any output stall. The double-dabble
//  loop converts one bit per cycle. Reset returns the step counter to the
//  wait step. A stalled digit holds until taken; no new value is taken
//  meanwhile.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_unit_macros.svh"

module binary_to_decimal_ascii_unit #(
    parameter int VALUE_BITS = bdau_pkg::VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [bdau_pkg::TDATA_IN_BITS-1:0]  i_s_tdata,   // [31:0] value
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [bdau_pkg::TDATA_OUT_BITS-1:0] o_m_tdata,   // [5:0] digit_char
    output logic                                o_m_tlast
);

    localparam int NDIG      = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BCD_BITS  = 4 * NDIG;
    localparam int BCNT_BITS = $clog2(VALUE_BITS + 1);
    localparam int DCNT_BITS = $clog2(NDIG + 1);

    logic [bdau_pkg::STEP_BITS-1:0] r_pc, n_pc;
    logic [VALUE_BITS-1:0]          r_bin, n_bin;
    logic [BCD_BITS-1:0]            r_bcd, n_bcd;
    logic [BCNT_BITS-1:0]           r_bcnt, n_bcnt;
    logic [DCNT_BITS-1:0]           r_dcnt, n_dcnt;

    bdau_pkg::t_uword uw;
    logic [BCD_BITS-1:0] adj;
    logic [3:0]          top;
    logic                in_acc, out_acc, bits_done, lead_done, out_last, cond_hit;

    assign uw  = bdau_pkg::ucode(r_pc);
    assign top = r_bcd[BCD_BITS-1 -: 4];

    assign in_acc    = i_s_tvalid & uw.s_ready;
    assign out_acc   = i_m_tready & uw.m_valid;
    assign bits_done = (r_bcnt == BCNT_BITS'(1));
    assign lead_done = (top != 4'd0) || (r_dcnt == DCNT_BITS'(1));
    assign out_last  = i_m_tready && (r_dcnt == DCNT_BITS'(1));

    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_comb begin
        case (uw.cond)
            bdau_pkg::COND_IN_ACC:    cond_hit = in_acc;
            bdau_pkg::COND_BITS_DONE: cond_hit = bits_done;
            bdau_pkg::COND_LEAD_DONE: cond_hit = lead_done;
            bdau_pkg::COND_OUT_LAST:  cond_hit = out_last;
            default:                  cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_pc   = cond_hit ? uw.jump : r_pc;
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        n_bcnt = r_bcnt;
        n_dcnt = r_dcnt;
        if (in_acc) begin
            n_bin  = VALUE_BITS'(i_s_tdata);
            n_bcd  = '0;
            n_bcnt = BCNT_BITS'(VALUE_BITS);
            n_dcnt = DCNT_BITS'(NDIG);
        end
        if (uw.conv_en) begin
            n_bcd  = {adj[BCD_BITS-2:0], r_bin[VALUE_BITS-1]};
            n_bin  = {r_bin[VALUE_BITS-2:0], 1'b0};
            n_bcnt = r_bcnt - BCNT_BITS'(1);
        end
        if ((uw.skip_en && !lead_done) || out_acc) begin
            n_bcd  = {r_bcd[BCD_BITS-5:0], 4'd0};
            n_dcnt = r_dcnt - DCNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= bdau_pkg::STEP_WAIT;
            r_bcnt <= '0;
            r_dcnt <= DCNT_BITS'(NDIG);
        end else begin
            r_pc   <= n_pc;
            r_bcnt <= n_bcnt;
            r_dcnt <= n_dcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_s_tready = uw.s_ready;
    assign o_m_tvalid = uw.m_valid;
    assign o_m_tdata  = {2'b00, bdau_pkg::ASCII_ZERO + {2'b00, top}};
    assign o_m_tlast  = (r_dcnt == DCNT_BITS'(1));

    `BDAU_ASSERT_ALWAYS(a_no_overlap, i_clk, i_rst_n, !(o_s_tready && o_m_tvalid))
    `BDAU_ASSERT_ALWAYS(a_dcnt_nonzero, i_clk, i_rst_n, !o_m_tvalid || (r_dcnt != '0))
    `BDAU_ASSERT_NEXT(a_load_conv, i_clk, i_rst_n, in_acc,
        (r_pc == bdau_pkg::STEP_CONV) && (r_bcnt == BCNT_BITS'(VALUE_BITS)))
    `BDAU_ASSERT_NEXT(a_last_ready, i_clk, i_rst_n,
        o_m_tvalid && i_m_tready && o_m_tlast, o_s_tready)

endmodule
